>>> sv/rv64m_pkg.sv
// Shared types and operation codes for the RV64M multiply pipeline.
package rv64m_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned HLEN = XLEN / 2;

  typedef logic [1:0] op_t;

  localparam op_t OP_MUL     = 2'd0;
  localparam op_t OP_MULH    = 2'd1;
  localparam op_t OP_HIGH_SU = 2'd2;
  localparam op_t OP_HIGH_UU = 2'd3;

  typedef logic [XLEN-1:0] xword_t;

  typedef struct packed {
    logic valid;
    op_t  op;
    logic word;
  } ctl_t;

endpackage

>>> sv/rv64m_pp.sv
// First pipeline stage: four 32x32 partial products and the signed-high correction term.
module rv64m_pp import rv64m_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  ctl_t   ctl_in,
  input  xword_t a,
  input  xword_t b,
  output ctl_t   ctl_out,
  output xword_t p00,
  output xword_t p01,
  output xword_t p10,
  output xword_t p11,
  output xword_t corr
);

  logic   a_neg;
  logic   b_neg;
  xword_t corr_next;

  always_comb begin
    a_neg     = a[XLEN-1] & ((ctl_in.op == OP_MULH) || (ctl_in.op == OP_HIGH_SU));
    b_neg     = b[XLEN-1] & (ctl_in.op == OP_MULH);
    corr_next = (a_neg ? b : '0) + (b_neg ? a : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.op   <= ctl_in.op;
    ctl_out.word <= ctl_in.word;
    p00          <= a[HLEN-1:0]    * b[HLEN-1:0];
    p01          <= a[HLEN-1:0]    * b[XLEN-1:HLEN];
    p10          <= a[XLEN-1:HLEN] * b[HLEN-1:0];
    p11          <= a[XLEN-1:HLEN] * b[XLEN-1:HLEN];
    corr         <= corr_next;
  end

endmodule

>>> sv/rv64m_acc.sv
// Second and third pipeline stages: partial product accumulation and result select.
module rv64m_acc import rv64m_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  ctl_t   ctl_in,
  input  xword_t p00,
  input  xword_t p01,
  input  xword_t p10,
  input  xword_t p11,
  input  xword_t corr,
  output logic   done,
  output xword_t product_word
);

  logic [HLEN+1:0] mid;
  xword_t          hi_part_next;

  ctl_t            ctl2;
  xword_t          lo;
  xword_t          hi_part;
  logic [1:0]      carry;
  xword_t          corr2;

  xword_t          hi;
  xword_t          result_next;

  always_comb begin
    mid = (HLEN+2)'(p00[XLEN-1:HLEN]) + (HLEN+2)'(p01[HLEN-1:0])
        + (HLEN+2)'(p10[HLEN-1:0]);
    hi_part_next = p11 + XLEN'(p01[XLEN-1:HLEN]) + XLEN'(p10[XLEN-1:HLEN]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else begin
      ctl2.valid <= ctl_in.valid;
    end
    ctl2.op   <= ctl_in.op;
    ctl2.word <= ctl_in.word;
    lo        <= {mid[HLEN-1:0], p00[HLEN-1:0]};
    carry     <= mid[HLEN+1:HLEN];
    hi_part   <= hi_part_next;
    corr2     <= corr;
  end

  always_comb begin
    hi = hi_part + XLEN'(carry) - corr2;
    if (ctl2.op == OP_MUL) begin
      result_next = ctl2.word ? {{HLEN{lo[HLEN-1]}}, lo[HLEN-1:0]} : lo;
    end else begin
      result_next = hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl2.valid;
    end
  end

  always_ff @(posedge clk) begin
    product_word <= result_next;
  end

endmodule

>>> sv/rv64_multiply_unit.sv
// Top level of the RV64M multiplier (low, high and word products).
//
// Usage: drive op, word_op, operand_a and operand_b and pulse start. A
// transaction is taken at every rising edge with start high and busy low;
// busy stays low, so a new transaction can be issued in every cycle.
// Each transaction passes through the register stages named below and
// shows its product_word with done high for exactly one cycle.
// Throughput is one transaction per cycle, set by the three register
// stages (32x32 partial products, partial sum, final add and select)
// that each take a new transaction every cycle.
// op selects the low product, or the high half as signed x signed,
// signed x unsigned or unsigned x unsigned; word_op applies to the low
// product only and returns the sign-extended 32-bit product.
// Reset clears the valid bits of all stages; transactions in flight are
// dropped and done stays low until new work arrives. The receiver cannot
// stall: each result is present for one cycle only.
module rv64_multiply_unit import rv64m_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic        word_op,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  output logic        done,
  output logic [63:0] product_word
);

  ctl_t   ctl_in;
  ctl_t   ctl1;
  xword_t p00;
  xword_t p01;
  xword_t p10;
  xword_t p11;
  xword_t corr;

  assign busy = 1'b0;

  always_comb begin
    ctl_in.valid = start & ~busy;
    ctl_in.op    = op;
    ctl_in.word  = word_op;
  end

  rv64m_pp u_pp (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_in),
    .a       (operand_a),
    .b       (operand_b),
    .ctl_out (ctl1),
    .p00     (p00),
    .p01     (p01),
    .p10     (p10),
    .p11     (p11),
    .corr    (corr)
  );

  rv64m_acc u_acc (
    .clk          (clk),
    .rst          (rst),
    .ctl_in       (ctl1),
    .p00          (p00),
    .p01          (p01),
    .p10          (p10),
    .p11          (p11),
    .corr         (corr),
    .done         (done),
    .product_word (product_word)
  );

endmodule
